@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks on a clock, disabled while the reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/swhs_pkg.sv @@
// ----------------------------------------------------------------------------
// swhs_pkg
// Types and constants of the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhs_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int FRAME_BITS  = 8 * FRAME_BYTES;
    localparam int BIT_IDX_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int TICK_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH   = 2'd2;

    localparam logic [TICK_W-1:0] START_LOW_RST    = 16'd2000;
    localparam logic [TICK_W-1:0] RELEASE_WAIT_RST = 16'd40;
    localparam logic [TICK_W-1:0] ONE_THRESH_RST   = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] humidity_raw;
        logic [15:0] temperature_raw;
        logic [7:0]  checksum_byte;
        logic        checksum_ok;
    } t_result;

endpackage

@@ rtl/swhs_in_if.sv @@
// ----------------------------------------------------------------------------
// swhs_in_if
// Input channel: one timer tick with a line sample, or a start request.
// ----------------------------------------------------------------------------
interface swhs_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic line_level;

    modport source (output valid, output kind, output line_level, input ready);
    modport sink   (input valid, input kind, input line_level, output ready);
endinterface

@@ rtl/swhs_out_if.sv @@
// ----------------------------------------------------------------------------
// swhs_out_if
// Result channel: line drive, status flags and the decoded frame.
// ----------------------------------------------------------------------------
interface swhs_out_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] humidity_raw;
    logic [15:0] temperature_raw;
    logic [7:0]  checksum_byte;
    logic        checksum_ok;

    modport source (
        output valid, output drive_low, output busy_res, output done_res,
        output humidity_raw, output temperature_raw, output checksum_byte,
        output checksum_ok, input ready
    );
    modport sink (
        input valid, input drive_low, input busy_res, input done_res,
        input humidity_raw, input temperature_raw, input checksum_byte,
        input checksum_ok, output ready
    );
endinterface

@@ rtl/single_wire_humidity_sensor_reader.sv @@
// Throughput: one item per cycle while the skid entry is empty; the whole protocol
// step is one pass of logic. Results are registered in a two-entry output buffer
// whose skid entry takes one input transfer while the output is stalled.
// Synchronous active-low reset: phase idle, counters and frame cleared,
// configuration registers back to 2000, 40 and 100 ticks.
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Start pulse, response tracking and 40-bit frame decode with checksum check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module single_wire_humidity_sensor_reader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    swhs_in_if.sink                             i_in,
    swhs_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [swhs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swhs_pkg::TICK_W-1:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_START_LOW, PH_RELEASE, PH_RESP_LOW,
        PH_RESP_HIGH, PH_RESP_END, PH_BIT_GAP, PH_BIT_HIGH
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [swhs_pkg::TICK_W-1:0]       r_tick_count, n_tick_count;
    logic [swhs_pkg::BIT_IDX_W-1:0]    r_bit_index, n_bit_index;
    logic [swhs_pkg::FRAME_BITS-1:0]   r_shift_bits, n_shift_bits;
    logic [swhs_pkg::TICK_W-1:0]       r_start_low, r_release_wait, r_one_thresh;

    swhs_pkg::t_result r_out, r_skid, n_res;
    logic              r_out_valid, r_skid_valid;

    logic                              accept;
    logic                              done;
    logic [swhs_pkg::TICK_W-1:0]       tick_inc;
    logic [swhs_pkg::BIT_IDX_W-1:0]    bit_next;
    logic [7:0]                        b0, b1, b2, b3, b4;

    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && !r_skid_valid;
    assign tick_inc   = (r_tick_count == swhs_pkg::TICK_MAX) ? r_tick_count
                                                             : r_tick_count + 16'd1;
    assign bit_next   = r_bit_index + 6'd1;

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift_bits = r_shift_bits;
        done         = 1'b0;
        if (i_in.kind == swhs_pkg::KIND_START) begin
            n_phase      = PH_START_LOW;
            n_tick_count = '0;
            n_bit_index  = '0;
            n_shift_bits = '0;
        end else begin
            case (r_phase)
                PH_START_LOW: begin
                    n_tick_count = tick_inc;
                    if (tick_inc >= r_start_low) begin
                        n_phase      = PH_RELEASE;
                        n_tick_count = '0;
                    end
                end
                PH_RELEASE: begin
                    n_tick_count = tick_inc;
                    if (tick_inc >= r_release_wait) begin
                        n_phase = PH_RESP_LOW;
                    end
                end
                PH_RESP_LOW: begin
                    if (!i_in.line_level) n_phase = PH_RESP_HIGH;
                end
                PH_RESP_HIGH: begin
                    if (i_in.line_level) n_phase = PH_RESP_END;
                end
                PH_RESP_END: begin
                    if (!i_in.line_level) n_phase = PH_BIT_GAP;
                end
                PH_BIT_GAP: begin
                    if (i_in.line_level) begin
                        n_phase      = PH_BIT_HIGH;
                        n_tick_count = 16'd1;
                    end
                end
                PH_BIT_HIGH: begin
                    if (i_in.line_level) begin
                        n_tick_count = tick_inc;
                    end else begin
                        // The falling edge ends the bit; its high time decides the value.
                        n_shift_bits = {r_shift_bits[swhs_pkg::FRAME_BITS-2:0],
                                        (r_tick_count > r_one_thresh)};
                        if (bit_next >= swhs_pkg::BIT_IDX_W'(swhs_pkg::FRAME_BITS)) begin
                            n_phase     = PH_IDLE;
                            n_bit_index = '0;
                            done        = 1'b1;
                        end else begin
                            n_phase     = PH_BIT_GAP;
                            n_bit_index = bit_next;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    assign b0 = n_shift_bits[39:32];
    assign b1 = n_shift_bits[31:24];
    assign b2 = n_shift_bits[23:16];
    assign b3 = n_shift_bits[15:8];
    assign b4 = n_shift_bits[7:0];

    always_comb begin
        n_res.drive_low       = (n_phase == PH_START_LOW);
        n_res.busy_res        = (n_phase != PH_IDLE);
        n_res.done_res        = done;
        n_res.humidity_raw    = {b0, b1};
        n_res.temperature_raw = {b2, b3};
        n_res.checksum_byte   = b4;
        n_res.checksum_ok     = ((b0 + b1 + b2 + b3) == b4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_tick_count   <= '0;
            r_bit_index    <= '0;
            r_shift_bits   <= '0;
            r_start_low    <= swhs_pkg::START_LOW_RST;
            r_release_wait <= swhs_pkg::RELEASE_WAIT_RST;
            r_one_thresh   <= swhs_pkg::ONE_THRESH_RST;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swhs_pkg::CFG_START_LOW:    r_start_low    <= i_cfg_data;
                    swhs_pkg::CFG_RELEASE_WAIT: r_release_wait <= i_cfg_data;
                    swhs_pkg::CFG_ONE_THRESH:   r_one_thresh   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase      <= n_phase;
                r_tick_count <= n_tick_count;
                r_bit_index  <= n_bit_index;
                r_shift_bits <= n_shift_bits;
            end
            // Output register drains first; the skid entry catches a transfer
            // that arrives while the output is stalled.
            if (o_out.ready || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (accept) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (accept) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.drive_low       = r_out.drive_low;
    assign o_out.busy_res        = r_out.busy_res;
    assign o_out.done_res        = r_out.done_res;
    assign o_out.humidity_raw    = r_out.humidity_raw;
    assign o_out.temperature_raw = r_out.temperature_raw;
    assign o_out.checksum_byte   = r_out.checksum_byte;
    assign o_out.checksum_ok     = r_out.checksum_ok;

    `ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid entry without output entry")
    `ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && r_out_valid && !o_out.ready, r_skid_valid, "skid entry lost during stall")
    `ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res, "done result while still busy")
    `ASSERT_IMP(a_drive_busy, i_clk, i_rst_n, r_out_valid && r_out.drive_low, r_out.busy_res, "line driven low outside a read")
    `ASSERT_IMP(a_idle_index, i_clk, i_rst_n, r_phase == PH_IDLE, r_bit_index == '0, "bit index left nonzero in idle")

endmodule

@@ verif/tb_single_wire_humidity_sensor_reader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_wire_humidity_sensor_reader
// Streams timer ticks and start requests into the reader and compares every
// returned reading against a cycle-free model of the sensor protocol. Most
// traffic is well-formed sensor responses with random frame contents; the
// rest is noise and reads cut short at a random bit boundary.
// ----------------------------------------------------------------------------
module tb_single_wire_humidity_sensor_reader;

    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [2:0] {
        RD_IDLE, RD_START_LOW, RD_RELEASE, RD_RESP_LOW,
        RD_RESP_HIGH, RD_RESP_END, RD_BIT_GAP, RD_BIT_HIGH
    } t_read_phase;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} t_stall_mode;

    typedef struct packed {
        logic kind;
        logic level;
    } t_sample;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [swhs_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [swhs_pkg::TICK_W-1:0]    cfg_data;

    swhs_in_if  sample_if ();
    swhs_out_if reading_if ();

    single_wire_humidity_sensor_reader i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (sample_if),
        .o_out      (reading_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Model of the reader: configuration and protocol state.
    logic [swhs_pkg::TICK_W-1:0]     cfg_low_ticks     = swhs_pkg::START_LOW_RST;
    logic [swhs_pkg::TICK_W-1:0]     cfg_release_ticks = swhs_pkg::RELEASE_WAIT_RST;
    logic [swhs_pkg::TICK_W-1:0]     cfg_threshold     = swhs_pkg::ONE_THRESH_RST;
    t_read_phase                     rd_phase = RD_IDLE;
    logic [swhs_pkg::TICK_W-1:0]     rd_ticks = '0;
    logic [swhs_pkg::BIT_IDX_W-1:0]  rd_bits  = '0;
    logic [swhs_pkg::FRAME_BITS-1:0] rd_frame = '0;

    t_sample           queued_samples[$];
    swhs_pkg::t_result pending_readings[$];
    int                samples_queued = 0;
    int                errors = 0;

    int          burst_left = 0;
    int          gap_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [swhs_pkg::TICK_W-1:0] sat_inc(
        input logic [swhs_pkg::TICK_W-1:0] v);
        return (v == swhs_pkg::TICK_MAX) ? v : v + 1'b1;
    endfunction

    function automatic swhs_pkg::t_result advance_reader(input logic kind, input logic level);
        swhs_pkg::t_result r;
        logic              done;
        logic [7:0]        b0, b1, b2, b3, b4, sum;
        done = 1'b0;
        if (kind == swhs_pkg::KIND_START) begin
            rd_phase = RD_START_LOW;
            rd_ticks = '0;
            rd_bits  = '0;
            rd_frame = '0;
        end else begin
            case (rd_phase)
                RD_IDLE: ;
                RD_START_LOW: begin
                    rd_ticks = sat_inc(rd_ticks);
                    if (rd_ticks >= cfg_low_ticks) begin
                        rd_phase = RD_RELEASE;
                        rd_ticks = '0;
                    end
                end
                RD_RELEASE: begin
                    rd_ticks = sat_inc(rd_ticks);
                    if (rd_ticks >= cfg_release_ticks) rd_phase = RD_RESP_LOW;
                end
                RD_RESP_LOW:  if (!level) rd_phase = RD_RESP_HIGH;
                RD_RESP_HIGH: if (level) rd_phase = RD_RESP_END;
                RD_RESP_END:  if (!level) rd_phase = RD_BIT_GAP;
                RD_BIT_GAP: begin
                    if (level) begin
                        rd_phase = RD_BIT_HIGH;
                        rd_ticks = 16'd1;
                    end
                end
                RD_BIT_HIGH: begin
                    if (level) begin
                        rd_ticks = sat_inc(rd_ticks);
                    end else begin
                        rd_frame = {rd_frame[swhs_pkg::FRAME_BITS-2:0],
                                    rd_ticks > cfg_threshold};
                        rd_bits  = rd_bits + 1'b1;
                        if (rd_bits >= swhs_pkg::FRAME_BITS) begin
                            rd_phase = RD_IDLE;
                            rd_bits  = '0;
                            done     = 1'b1;
                        end else begin
                            rd_phase = RD_BIT_GAP;
                        end
                    end
                end
                default: rd_phase = RD_IDLE;
            endcase
        end
        {b0, b1, b2, b3, b4} = rd_frame;
        sum = b0 + b1 + b2 + b3;
        r.drive_low       = (rd_phase == RD_START_LOW);
        r.busy_res        = (rd_phase != RD_IDLE);
        r.done_res        = done;
        r.humidity_raw    = {b0, b1};
        r.temperature_raw = {b2, b3};
        r.checksum_byte   = b4;
        r.checksum_ok     = (sum == b4);
        return r;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic push_sample(input logic kind, input logic level);
        queued_samples.push_back(t_sample'{kind, level});
        samples_queued++;
    endtask

    task automatic push_run(input logic level, input int n);
        repeat (n) push_sample(swhs_pkg::KIND_TICK, level);
    endtask

    task automatic queue_noise(input int n);
        repeat (n) push_sample(($urandom_range(0, 15) == 0) ? swhs_pkg::KIND_START
                                                            : swhs_pkg::KIND_TICK,
                               rand_bit());
    endtask

    // One sensor read: start pulse, release, response and 40 data bits.
    // When cut_short is set the frame stops at a random bit boundary.
    task automatic queue_read(input bit cut_short);
        logic [swhs_pkg::FRAME_BITS-1:0] frame;
        int stop_bit;
        int hi;
        int thr;
        frame = {8'($urandom), $urandom};
        case ($urandom_range(0, 7))
            0: frame = '0;
            1: frame = '1;
            default: ;
        endcase
        if (rand_bit())
            frame[7:0] = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
        stop_bit = cut_short ? $urandom_range(0, swhs_pkg::FRAME_BITS - 1) : -1;
        thr = int'(cfg_threshold);

        push_sample(swhs_pkg::KIND_START, rand_bit());
        repeat ((cfg_low_ticks == 0) ? 1 : int'(cfg_low_ticks))
            push_sample(swhs_pkg::KIND_TICK, rand_bit());
        repeat ((cfg_release_ticks == 0) ? 1 : int'(cfg_release_ticks))
            push_sample(swhs_pkg::KIND_TICK, rand_bit());

        push_run(1'b1, $urandom_range(0, 2));
        push_run(1'b0, 1 + $urandom_range(0, 2));
        push_run(1'b1, 1 + $urandom_range(0, 2));
        push_sample(swhs_pkg::KIND_TICK, 1'b0);

        for (int b = swhs_pkg::FRAME_BITS - 1; b >= 0; b--) begin
            if (b == stop_bit) return;
            push_run(1'b0, $urandom_range(0, 2));
            // Very long thresholds are only exercised with short pulses.
            if (thr > 1000)
                hi = $urandom_range(1, 3);
            else if (frame[b])
                hi = thr + 1 + $urandom_range(0, 2);
            else if (thr == 0)
                hi = 1;
            else
                hi = $urandom_range((thr > 2) ? thr - 2 : 1, thr);
            push_run(1'b1, hi);
            push_sample(swhs_pkg::KIND_TICK, 1'b0);
        end
    endtask

    task automatic run_random(input int min_items, input int min_reads);
        int first;
        int reads;
        int pick;
        first = samples_queued;
        reads = 0;
        while (samples_queued - first < min_items || reads < min_reads) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                queue_read(1'b0);
                reads++;
            end else if (pick < 17) begin
                queue_read(1'b1);
            end else begin
                queue_noise($urandom_range(4, 30));
            end
        end
    endtask

    task automatic wait_drained();
        while (queued_samples.size() != 0 || sample_if.valid
               || pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [swhs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swhs_pkg::TICK_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            swhs_pkg::CFG_START_LOW:    cfg_low_ticks     = val;
            swhs_pkg::CFG_RELEASE_WAIT: cfg_release_ticks = val;
            swhs_pkg::CFG_ONE_THRESH:   cfg_threshold     = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [swhs_pkg::TICK_W-1:0] low_ticks,
                              input logic [swhs_pkg::TICK_W-1:0] release_ticks,
                              input logic [swhs_pkg::TICK_W-1:0] threshold);
        wait_drained();
        write_reg(swhs_pkg::CFG_START_LOW, low_ticks);
        write_reg(swhs_pkg::CFG_RELEASE_WAIT, release_ticks);
        write_reg(swhs_pkg::CFG_ONE_THRESH, threshold);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Input side: bursts of transfers separated by random gaps.
    always @(posedge i_clk) begin : sample_driver
        t_sample item;
        logic    send;
        if (!i_rst_n) begin
            sample_if.valid <= 1'b0;
        end else begin
            if (sample_if.valid && sample_if.ready)
                pending_readings.push_back(advance_reader(sample_if.kind,
                                                          sample_if.line_level));
            if (!sample_if.valid || sample_if.ready) begin
                send = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (queued_samples.size() != 0) begin
                    send = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
                if (send) begin
                    item = queued_samples.pop_front();
                    sample_if.valid      <= 1'b1;
                    sample_if.kind       <= item.kind;
                    sample_if.line_level <= item.level;
                end else begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each reading transfer and stalls in changing modes.
    always @(posedge i_clk) begin : reading_monitor
        swhs_pkg::t_result seen;
        swhs_pkg::t_result want;
        logic              rdy;
        if (!i_rst_n) begin
            reading_if.ready <= 1'b0;
        end else begin
            if (reading_if.valid && reading_if.ready) begin
                seen = '{drive_low:       reading_if.drive_low,
                         busy_res:        reading_if.busy_res,
                         done_res:        reading_if.done_res,
                         humidity_raw:    reading_if.humidity_raw,
                         temperature_raw: reading_if.temperature_raw,
                         checksum_byte:   reading_if.checksum_byte,
                         checksum_ok:     reading_if.checksum_ok};
                if (pending_readings.size() == 0) begin
                    $display("%0t: reading transfer with none expected, expected none, actual %h",
                             $time, seen);
                    errors++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("drive_low", 16'(want.drive_low), 16'(seen.drive_low));
                    check_field("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(seen.done_res));
                    check_field("humidity_raw", want.humidity_raw, seen.humidity_raw);
                    check_field("temperature_raw", want.temperature_raw,
                                seen.temperature_raw);
                    check_field("checksum_byte", 16'(want.checksum_byte),
                                16'(seen.checksum_byte));
                    check_field("checksum_ok", 16'(want.checksum_ok), 16'(seen.checksum_ok));
                end
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                mode_left  = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:   rdy = 1'b1;
                STALL_RANDOM: rdy = ($urandom_range(0, 3) != 0);
                default: begin
                    if (hold_left != 0) begin
                        hold_left--;
                        rdy = 1'b0;
                    end else begin
                        rdy = ($urandom_range(0, 5) != 0);
                        if (!rdy) hold_left = $urandom_range(1, 15);
                    end
                end
            endcase
            reading_if.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((sample_if.valid && sample_if.ready) || (reading_if.valid && reading_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL single_wire_humidity_sensor_reader");
                $finish;
            end
        end
    end

    initial begin : main_seq
        logic [swhs_pkg::TICK_W-1:0] low_ticks;
        logic [swhs_pkg::TICK_W-1:0] release_ticks;
        logic [swhs_pkg::TICK_W-1:0] threshold;
        sample_if.valid      = 1'b0;
        sample_if.kind       = swhs_pkg::KIND_TICK;
        sample_if.line_level = 1'b0;
        reading_if.ready     = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = swhs_pkg::CFG_START_LOW;
        cfg_data = '0;
        i_rst_n  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Idle ticks, then the first part of a start pulse at the reset settings.
        push_sample(swhs_pkg::KIND_TICK, 1'b0);
        push_sample(swhs_pkg::KIND_TICK, 1'b1);
        push_sample(swhs_pkg::KIND_START, 1'b0);
        push_run(1'b1, 8);

        // Shortest timing: one-tick start pulse, zero release wait.
        set_config(16'd1, 16'd0, 16'd0);
        push_sample(swhs_pkg::KIND_TICK, 1'b1);
        push_sample(swhs_pkg::KIND_START, 1'b1);
        push_sample(swhs_pkg::KIND_TICK, 1'b0);
        push_sample(swhs_pkg::KIND_TICK, 1'b1);
        push_run(1'b1, 2);
        push_run(1'b0, 2);
        push_run(1'b1, 2);
        push_sample(swhs_pkg::KIND_TICK, 1'b0);
        push_sample(swhs_pkg::KIND_TICK, 1'b1);
        push_sample(swhs_pkg::KIND_TICK, 1'b0);
        // A start request in the middle of the data bits restarts the read.
        push_sample(swhs_pkg::KIND_START, 1'b0);
        push_sample(swhs_pkg::KIND_TICK, 1'b1);
        push_sample(swhs_pkg::KIND_START, 1'b1);
        push_sample(swhs_pkg::KIND_START, 1'b0);
        push_sample(swhs_pkg::KIND_TICK, 1'b0);
        push_sample(swhs_pkg::KIND_TICK, 1'b1);
        run_random(20, 1);

        low_ticks     = 16'($urandom_range(1, 4));
        release_ticks = 16'($urandom_range(0, 3));
        threshold     = 16'($urandom_range(0, 2));
        set_config(low_ticks, release_ticks, threshold);
        run_random(20, 1);

        // Highest threshold: every bit decodes as a zero.
        set_config(16'd1, 16'd1, swhs_pkg::TICK_MAX);
        queue_read(1'b1);
        queue_noise(10);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS single_wire_humidity_sensor_reader");
        end else begin
            $display("FAIL single_wire_humidity_sensor_reader");
        end
        $finish;
    end

endmodule
